@@ src/bpq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_pkg: shared types and constants for the bounded priority queue
// Entry geometry, operation and status codes, controller types and helpers.
// ----------------------------------------------------------------------------
package bpq_pkg;

  // Geometry
  localparam int DEPTH         = 16;
  localparam int KEY_WIDTH     = 16;
  localparam int PAYLOAD_WIDTH = 16;
  localparam int COUNT_W       = $clog2(DEPTH + 1);
  localparam int CAP_W         = 5;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 5;
  localparam int MODE_W        = 2;
  localparam int STATUS_W      = 2;

  // Capacity used when the capacity register holds zero
  localparam logic [CAP_W-1:0] DEFAULT_CAP = CAP_W'(10);

  // Request operations
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORDER    = 1'b0,
    CFG_CAPACITY = 1'b1
  } cfg_idx_t;

  // Controller states
  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch request fields
    logic execute;   // apply request to store, load result register
  } dp_cmd_t;

  // True when key a must be served strictly before key b
  function automatic logic key_before(input logic [KEY_WIDTH-1:0] a,
                                      input logic [KEY_WIDTH-1:0] b,
                                      input logic                 low_first);
    logic res;
    res = low_first ? (a < b) : (a > b);
    return res;
  endfunction

  // Capacity actually enforced: zero maps to default, saturates at depth
  function automatic logic [COUNT_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] c;
    c = (cap == '0) ? DEFAULT_CAP : cap;
    if ({1'b0, c} > (CAP_W+1)'(DEPTH)) begin
      c = CAP_W'(DEPTH);
    end
    return COUNT_W'(c);
  endfunction

endpackage
`default_nettype wire

@@ src/bounded_priority_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_priority_queue: sorted-array priority queue, 16 entries
// Insert, remove and peek on key/payload entries; ties leave first in,
// first out.
//
//   Channel  Direction  Handshake             Carries
//   in_      input      in_valid / in_ready   mode, entry_key, entry_payload
//   out_     output     out_valid / out_ready status, top entry, occupancy, flags
//   cfg_     input      cfg_valid / cfg_ready register index, write data
//
// A request is latched in the idle state; in the execute state the entry cells
// compare and shift in parallel and the result register loads.
// The execute cycle waits while the previous result is held by out_ready low.
// Synchronous active-low reset empties the queue; no clearing pass is needed.
// cfg_ready is always high; writes go straight to the configuration registers.
// ----------------------------------------------------------------------------
module bounded_priority_queue (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [bpq_pkg::MODE_W-1:0]            in_mode,
  input  wire logic [bpq_pkg::KEY_WIDTH-1:0]         in_entry_key,
  input  wire logic [bpq_pkg::PAYLOAD_WIDTH-1:0]     in_entry_payload,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [bpq_pkg::STATUS_W-1:0]               out_status,
  output logic [bpq_pkg::KEY_WIDTH-1:0]              out_top_key,
  output logic [bpq_pkg::PAYLOAD_WIDTH-1:0]          out_top_payload,
  output logic [bpq_pkg::COUNT_W-1:0]                out_occupancy,
  output logic                                       out_full_flag,
  output logic                                       out_empty_flag,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [bpq_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [bpq_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import bpq_pkg::*;

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  // Sequencer
  bpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Entry cells, config and result register
  bpq_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_mode          (in_mode),
    .in_entry_key     (in_entry_key),
    .in_entry_payload (in_entry_payload),
    .out_status       (out_status),
    .out_top_key      (out_top_key),
    .out_top_payload  (out_top_payload),
    .out_occupancy    (out_occupancy),
    .out_full_flag    (out_full_flag),
    .out_empty_flag   (out_empty_flag)
  );

endmodule
`default_nettype wire

@@ src/bpq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_ctrl: request sequencer
// Accepts one request, runs it through the datapath once the result register
// is free, and tracks the result valid flag.
// ----------------------------------------------------------------------------
module bpq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output bpq_pkg::dp_cmd_t     cmd
);
  import bpq_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  // Result register can be reloaded when empty or being drained
  assign slot_free = !out_valid_r || out_ready;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (in_valid) state_nxt = CS_EXEC;
      end
      CS_EXEC: begin
        if (slot_free) state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    case (state_r)
      CS_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      CS_EXEC: begin
        cmd.execute = slot_free;
      end
      default: ;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

@@ src/bpq_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_datapath: sorted register array with per-cell compare and shift
// Holds configuration, the request, the entry cells, the count and the
// result register.
// ----------------------------------------------------------------------------
module bpq_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire bpq_pkg::dp_cmd_t                      cmd,
  input  wire logic                                  cfg_we,
  input  wire logic [bpq_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [bpq_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic [bpq_pkg::MODE_W-1:0]            in_mode,
  input  wire logic [bpq_pkg::KEY_WIDTH-1:0]         in_entry_key,
  input  wire logic [bpq_pkg::PAYLOAD_WIDTH-1:0]     in_entry_payload,
  output logic [bpq_pkg::STATUS_W-1:0]               out_status,
  output logic [bpq_pkg::KEY_WIDTH-1:0]              out_top_key,
  output logic [bpq_pkg::PAYLOAD_WIDTH-1:0]          out_top_payload,
  output logic [bpq_pkg::COUNT_W-1:0]                out_occupancy,
  output logic                                       out_full_flag,
  output logic                                       out_empty_flag
);
  import bpq_pkg::*;

  // Configuration
  logic               order_r;
  logic [CAP_W-1:0]   cap_r;

  // Latched request
  mode_t                    mode_r;
  logic [KEY_WIDTH-1:0]     key_r;
  logic [PAYLOAD_WIDTH-1:0] pay_r;

  // Entry cells and count
  logic [KEY_WIDTH-1:0]     cell_key_r [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] cell_pay_r [DEPTH];
  logic [KEY_WIDTH-1:0]     cell_key_nxt [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] cell_pay_nxt [DEPTH];
  logic [COUNT_W-1:0]       count_r, count_nxt;

  // Result register
  logic [STATUS_W-1:0]      res_status_r, res_status_nxt;
  logic [KEY_WIDTH-1:0]     res_key_r, res_key_nxt;
  logic [PAYLOAD_WIDTH-1:0] res_pay_r, res_pay_nxt;
  logic [COUNT_W-1:0]       res_count_r;
  logic                     res_full_r, res_full_nxt;
  logic                     res_empty_r, res_empty_nxt;

  logic [COUNT_W-1:0]       cap_eff;
  logic [DEPTH-1:0]         hit, first_hit, at_or_after;
  logic                     do_insert, do_remove;

  assign cap_eff = eff_capacity(cap_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 1'b0;
      cap_r   <= DEFAULT_CAP;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ORDER:    order_r <= cfg_data[0];
        CFG_CAPACITY: cap_r   <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= mode_t'(in_mode);
      key_r  <= in_entry_key;
      pay_r  <= in_entry_payload;
    end
  end

  // Per-cell compare: new key beats this cell, or cell is past the end
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit[i] = (COUNT_W'(i) >= count_r) || key_before(key_r, cell_key_r[i], order_r);
    end
  end

  // Insert position: lowest hit, and every cell from there on
  assign first_hit   = hit & (~hit + DEPTH'(1));
  assign at_or_after = ~(first_hit - DEPTH'(1));

  // Operation decode
  always_comb begin
    do_insert      = 1'b0;
    do_remove      = 1'b0;
    res_status_nxt = ST_DONE;
    res_key_nxt    = '0;
    res_pay_nxt    = '0;
    count_nxt      = count_r;
    case (mode_r)
      MODE_INSERT: begin
        if (count_r >= cap_eff) begin
          res_status_nxt = ST_FULL;
        end else begin
          do_insert = 1'b1;
          count_nxt = count_r + COUNT_W'(1);
        end
      end
      MODE_REMOVE, MODE_PEEK: begin
        if (count_r == '0) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          res_key_nxt = cell_key_r[0];
          res_pay_nxt = cell_pay_r[0];
          if (mode_r == MODE_REMOVE) begin
            do_remove = 1'b1;
            count_nxt = count_r - COUNT_W'(1);
          end
        end
      end
      default: ;
    endcase
    res_full_nxt  = (count_nxt >= cap_eff);
    res_empty_nxt = (count_nxt == '0);
  end

  // Cell next values: shift down on insert, shift up on remove
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_key_nxt[i] = cell_key_r[i];
      cell_pay_nxt[i] = cell_pay_r[i];
      if (do_insert) begin
        if (first_hit[i]) begin
          cell_key_nxt[i] = key_r;
          cell_pay_nxt[i] = pay_r;
        end else if (i > 0 && at_or_after[i]) begin
          cell_key_nxt[i] = cell_key_r[(i > 0) ? i - 1 : 0];
          cell_pay_nxt[i] = cell_pay_r[(i > 0) ? i - 1 : 0];
        end
      end else if (do_remove && i < DEPTH - 1) begin
        cell_key_nxt[i] = cell_key_r[(i < DEPTH - 1) ? i + 1 : i];
        cell_pay_nxt[i] = cell_pay_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Entry cells
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int i = 0; i < DEPTH; i++) begin
        cell_key_r[i] <= cell_key_nxt[i];
        cell_pay_r[i] <= cell_pay_nxt[i];
      end
    end
  end

  // Count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      res_status_r <= res_status_nxt;
      res_key_r    <= res_key_nxt;
      res_pay_r    <= res_pay_nxt;
      res_count_r  <= count_nxt;
      res_full_r   <= res_full_nxt;
      res_empty_r  <= res_empty_nxt;
    end
  end

  assign out_status      = res_status_r;
  assign out_top_key     = res_key_r;
  assign out_top_payload = res_pay_r;
  assign out_occupancy   = res_count_r;
  assign out_full_flag   = res_full_r;
  assign out_empty_flag  = res_empty_r;

endmodule
`default_nettype wire

@@ src/bpq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_checker: port-level checks for the bounded priority queue
// Watches handshakes and result consistency; bound to the top level.
// ----------------------------------------------------------------------------
module bpq_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [bpq_pkg::STATUS_W-1:0]      out_status,
  input wire logic [bpq_pkg::KEY_WIDTH-1:0]     out_top_key,
  input wire logic [bpq_pkg::PAYLOAD_WIDTH-1:0] out_top_payload,
  input wire logic [bpq_pkg::COUNT_W-1:0]       out_occupancy,
  input wire logic                              out_full_flag,
  input wire logic                              out_empty_flag
);
  import bpq_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_top_key) && $stable(out_occupancy))
    else $error("result changed while stalled");

  // One request at a time: ready drops after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another in flight");

  // Empty flag agrees with occupancy, and capacity is never zero
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_empty_flag == (out_occupancy == '0))
      && !(out_full_flag && out_empty_flag))
    else $error("inconsistent occupancy flags");

  // Empty report carries no entry
  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |->
      out_top_key == '0 && out_top_payload == '0 && out_empty_flag)
    else $error("empty report with entry data");

  // Refused insert implies full
  a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_full_flag && !out_empty_flag)
    else $error("full report without full flag");

endmodule

bind bounded_priority_queue bpq_checker u_bpq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_top_key     (out_top_key),
  .out_top_payload (out_top_payload),
  .out_occupancy   (out_occupancy),
  .out_full_flag   (out_full_flag),
  .out_empty_flag  (out_empty_flag)
);
`default_nettype wire

@@ sim/bounded_priority_queue_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_priority_queue_test: self-checking bench for the priority queue
// Drives insert, remove, peek and no-op requests under random idle and
// backpressure. A software copy of the sorted store predicts each result,
// which is checked field by field. Order and capacity change between phases
// while entries are still held.
// ----------------------------------------------------------------------------
module bounded_priority_queue_test;
  import bpq_pkg::*;

  typedef struct packed {
    status_t                  status;
    logic [KEY_WIDTH-1:0]     top_key;
    logic [PAYLOAD_WIDTH-1:0] top_payload;
    logic [COUNT_W-1:0]       occupancy;
    logic                     full_flag;
    logic                     empty_flag;
  } pq_result_t;

  logic                     clk;
  logic                     rst_n            = 1'b0;
  logic                     in_valid         = 1'b0;
  logic                     in_ready;
  logic [MODE_W-1:0]        in_mode          = MODE_NOP;
  logic [KEY_WIDTH-1:0]     in_entry_key     = '0;
  logic [PAYLOAD_WIDTH-1:0] in_entry_payload = '0;
  logic                     out_valid;
  logic                     out_ready        = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic [KEY_WIDTH-1:0]     out_top_key;
  logic [PAYLOAD_WIDTH-1:0] out_top_payload;
  logic [COUNT_W-1:0]       out_occupancy;
  logic                     out_full_flag;
  logic                     out_empty_flag;
  logic                     cfg_valid        = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index        = CFG_ORDER;
  logic [CFG_DATA_W-1:0]    cfg_data         = '0;

  // Shadow copy of the queue
  logic [KEY_WIDTH-1:0]     shadow_key [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] shadow_payload [DEPTH];
  int                       shadow_count;
  logic                     shadow_low_first;
  logic [CAP_W-1:0]         shadow_capacity;

  pq_result_t pending_results[$];
  int         error_count;
  logic       steady;  // no idling on either side while set

  bounded_priority_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_entry_key     (in_entry_key),
    .in_entry_payload (in_entry_payload),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_top_key      (out_top_key),
    .out_top_payload  (out_top_payload),
    .out_occupancy    (out_occupancy),
    .out_full_flag    (out_full_flag),
    .out_empty_flag   (out_empty_flag),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Enforced capacity: zero means the default, large values clip at depth
  function automatic int capacity_limit();
    int c;
    c = int'(shadow_capacity);
    if (c == 0) c = int'(DEFAULT_CAP);
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  // Apply one request to the shadow queue and return the result it causes
  function automatic pq_result_t apply_queue_request(mode_t op, logic [KEY_WIDTH-1:0] k,
                                                     logic [PAYLOAD_WIDTH-1:0] p);
    pq_result_t r;
    int         limit;
    int         pos;
    int         i;
    logic       found;
    r        = '0;
    r.status = ST_DONE;
    limit    = capacity_limit();
    case (op)
      MODE_INSERT: begin
        if (shadow_count >= limit || shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // new entry goes behind every key that is as good or better
          pos   = shadow_count;
          found = 1'b0;
          for (i = 0; i < shadow_count; i++) begin
            if (!found && (shadow_low_first ? (k < shadow_key[i]) : (k > shadow_key[i]))) begin
              pos   = i;
              found = 1'b1;
            end
          end
          for (i = shadow_count; i > pos; i--) begin
            shadow_key[i]     = shadow_key[i-1];
            shadow_payload[i] = shadow_payload[i-1];
          end
          shadow_key[pos]     = k;
          shadow_payload[pos] = p;
          shadow_count++;
        end
      end
      MODE_REMOVE, MODE_PEEK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.top_key     = shadow_key[0];
          r.top_payload = shadow_payload[0];
          if (op == MODE_REMOVE) begin
            for (i = 0; i + 1 < shadow_count; i++) begin
              shadow_key[i]     = shadow_key[i+1];
              shadow_payload[i] = shadow_payload[i+1];
            end
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    r.occupancy  = COUNT_W'(shadow_count);
    r.full_flag  = (shadow_count >= limit);
    r.empty_flag = (shadow_count == 0);
    return r;
  endfunction

  // Receiver backpressure
  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 31);
  end

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= 40) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endtask

  // Compare each returned result with the oldest prediction
  always @(posedge clk) begin
    pq_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with no request pending, expected none, actual status %0h",
                 $time, out_status);
      end else begin
        want = pending_results.pop_front();
        report_field("status", 32'(want.status), 32'(out_status));
        report_field("top_key", 32'(want.top_key), 32'(out_top_key));
        report_field("top_payload", 32'(want.top_payload), 32'(out_top_payload));
        report_field("occupancy", 32'(want.occupancy), 32'(out_occupancy));
        report_field("full_flag", 32'(want.full_flag), 32'(out_full_flag));
        report_field("empty_flag", 32'(want.empty_flag), 32'(out_empty_flag));
      end
    end
  end

  // Send one request and record its predicted result on acceptance
  task automatic send_request(mode_t op, logic [KEY_WIDTH-1:0] k, logic [PAYLOAD_WIDTH-1:0] p);
    if (!steady && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= op;
    in_entry_key     <= k;
    in_entry_payload <= p;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_queue_request(op, k, p));
  endtask

  // Stop sending and wait until every result is back and the block is quiet
  task automatic drain_requests();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    drain_requests();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ORDER) shadow_low_first = value[0];
    else shadow_capacity = CAP_W'(value);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_queue();
    send_request(MODE_PEEK, 16'h1234, 16'h5678);
    send_request(MODE_REMOVE, 16'hffff, 16'hffff);
    send_request(MODE_NOP, 16'h0000, 16'h0000);
  endtask

  // Key extremes and equal keys leaving first in, first out
  task automatic test_extremes_and_ties();
    send_request(MODE_INSERT, 16'h0000, 16'hffff);
    send_request(MODE_INSERT, 16'hffff, 16'h0000);
    send_request(MODE_INSERT, 16'h8000, 16'h1111);
    send_request(MODE_INSERT, 16'h8000, 16'h2222);
    send_request(MODE_NOP, 16'hffff, 16'hffff);
    send_request(MODE_PEEK, 16'h0000, 16'h0000);
    repeat (5) send_request(MODE_REMOVE, 16'h0000, 16'h0000);
  endtask

  task automatic test_capacity_one();
    write_register(CFG_CAPACITY, 5'd1);
    send_request(MODE_INSERT, 16'h1234, 16'haaaa);
    send_request(MODE_INSERT, 16'h5678, 16'h5555);
    send_request(MODE_PEEK, 16'h0000, 16'h0000);
    send_request(MODE_REMOVE, 16'h0000, 16'h0000);
  endtask

  // Order flipped with entries held: store stays, new inserts use new order
  task automatic test_order_switch();
    write_register(CFG_CAPACITY, 5'd0);
    write_register(CFG_ORDER, 5'b00001);
    send_request(MODE_INSERT, 16'd5, 16'h0005);
    send_request(MODE_INSERT, 16'd3, 16'h0003);
    write_register(CFG_ORDER, 5'b11110);
    send_request(MODE_INSERT, 16'd4, 16'h0004);
    repeat (3) send_request(MODE_REMOVE, 16'h0000, 16'h0000);
  endtask

  // Fill and drain in waves; entries carry over between settings
  task automatic run_random_phase(int n_items);
    logic                     filling;
    int                       r;
    mode_t                    op;
    logic [KEY_WIDTH-1:0]     k;
    filling = 1'b1;
    for (int n = 0; n < n_items; n++) begin
      if (shadow_count >= capacity_limit() && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (shadow_count == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 6) op = MODE_PEEK;
      else if (r < 9) op = MODE_NOP;
      else if (filling ? (r < 80) : (r < 30)) op = MODE_INSERT;
      else op = MODE_REMOVE;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: k = KEY_WIDTH'($urandom_range(0, 7));
        5:             k = '1;
        6:             k = '0;
        default:       k = KEY_WIDTH'($urandom);
      endcase
      send_request(op, k, PAYLOAD_WIDTH'($urandom));
      // at most one pause mid-stream until everything is back
      if (n == n_items / 2 && $urandom_range(0, 1) == 0) drain_requests();
    end
  endtask

  task automatic test_random_traffic();
    logic             order_seq [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic [CAP_W-1:0] cap_seq [8]   = '{5'd16, 5'd31, 5'd2, 5'd0, 5'd5, 5'd16, 5'd1, 5'd12};
    for (int ph = 0; ph < 8; ph++) begin
      write_register(CFG_ORDER, {4'($urandom_range(0, 15)), order_seq[ph]});
      write_register(CFG_CAPACITY, cap_seq[ph]);
      steady = (ph == 2);
      run_random_phase(235);
      steady = 1'b0;
    end
  endtask

  initial begin
    error_count      = 0;
    steady           = 1'b0;
    shadow_count     = 0;
    shadow_low_first = 1'b0;
    shadow_capacity  = DEFAULT_CAP;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_extremes_and_ties();
    test_capacity_one();
    test_order_switch();
    test_random_traffic();

    drain_requests();
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
